// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the top-level RTL file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("same-cycle implication violated");

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle implication violated");

`endif

// ===== sv/msms_pkg.sv =====
// ----------------------------------------------------------------------------
// msms_pkg
// Item kinds, field widths and lane interface types of the sample mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package msms_pkg;

	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_START = 2'd1,
		KIND_STOP  = 2'd2
	} kind_t;

	localparam int SAMPLE_W   = 16;
	localparam int LEN_IN_W   = 24;
	localparam int VOL_W      = 4;
	localparam int MIX_W      = 32;
	localparam int MASK_W     = 4;
	localparam int RAW_LANES  = 4;
	localparam logic [MIX_W-1:0] TAIL_MARGIN = 32'd1000;

	// Command given to each lane for one accepted item
	typedef struct packed {
		kind_t                 kind;
		logic                  sel;
		logic [LEN_IN_W-1:0]   length;
		logic                  loop_en;
		logic [VOL_W-1:0]      vol;
		logic [SAMPLE_W-1:0]   sample;
	} lane_cmd_t;

	// What one lane reports for one item
	typedef struct packed {
		logic [MIX_W-1:0] contrib;
		logic             consumed;
		logic             playing;
	} lane_res_t;

endpackage

`default_nettype wire

// ===== sv/msms_lane.sv =====
// ----------------------------------------------------------------------------
// msms_lane
// One channel: playback position, gain, and boxcar smoothing filter.
// ----------------------------------------------------------------------------
`default_nettype none

module msms_lane #(
	parameter int WINDOW_DEPTH = 16,
	parameter int WINDOW_SHIFT = 4,
	parameter int LENGTH_BITS  = 24
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                accept,
	input  wire msms_pkg::lane_cmd_t cmd,
	output msms_pkg::lane_res_t      res_s1
);
	import msms_pkg::*;

	localparam int IDX_W = $clog2(WINDOW_DEPTH);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(WINDOW_DEPTH - 1);

	logic                   playing_q;
	logic                   looping_q;
	logic [LENGTH_BITS-1:0] clip_q;
	logic [MIX_W-1:0]       tail_q;
	logic [LENGTH_BITS-1:0] pos_q;
	logic [VOL_W-1:0]       gain_q;
	logic [MIX_W-1:0]       held_q;
	logic [MIX_W-1:0]       total_q;
	logic [IDX_W-1:0]       idx_q;
	logic                   wrapped_q;
	logic [MIX_W-1:0]       rd_q;
	logic [MIX_W-1:0]       window_mem [WINDOW_DEPTH];

	logic                   tick;
	logic                   start;
	logic [LENGTH_BITS-1:0] clip_new;
	logic [LENGTH_BITS-1:0] pos_inc;
	logic                   at_end;
	logic [MIX_W-1:0]       held_cur;
	logic [LENGTH_BITS-1:0] pos_cur;
	logic                   play_tick;
	logic                   bypass;
	logic [MIX_W-1:0]       rd_data;
	logic [MIX_W-1:0]       total_cur;
	logic                   filt_we;
	logic [IDX_W-1:0]       idx_next;
	logic                   playing_d;

	// Decode the item for this lane
	assign tick     = accept && (cmd.kind == KIND_TICK);
	assign start    = accept && (cmd.kind == KIND_START) && cmd.sel;
	assign clip_new = LENGTH_BITS'(cmd.length);

	// Advance playback; position wraps to zero at the clip length when looping
	assign pos_inc   = pos_q + LENGTH_BITS'(1);
	assign at_end    = (pos_inc == clip_q);
	assign held_cur  = playing_q ? (MIX_W'(cmd.sample) << gain_q) : held_q;
	assign pos_cur   = playing_q ? ((at_end && looping_q) ? '0 : pos_inc) : pos_q;
	assign play_tick = playing_q && !(at_end && !looping_q);

	// Skip smoothing near the end of the clip
	assign bypass = (tail_q < MIX_W'(pos_cur));

	// Window entries read as zero until the index has wrapped once
	assign rd_data   = wrapped_q ? rd_q : '0;
	assign total_cur = total_q + held_cur - rd_data;
	assign filt_we   = tick && !bypass;
	assign idx_next  = (idx_q == IDX_LAST) ? '0 : idx_q + IDX_W'(1);

	// Next playing flag for any item kind
	always_comb begin
		playing_d = playing_q;
		if (accept) begin
			case (cmd.kind)
				KIND_TICK:  playing_d = play_tick;
				KIND_START: playing_d = cmd.sel ? 1'b1 : playing_q;
				KIND_STOP:  playing_d = cmd.sel ? 1'b0 : playing_q;
				default:    playing_d = playing_q;
			endcase
		end
	end

	// Channel and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			playing_q <= 1'b0;
			looping_q <= 1'b0;
			clip_q    <= '0;
			tail_q    <= '0 - TAIL_MARGIN;
			pos_q     <= '0;
			gain_q    <= '0;
			held_q    <= '0;
			total_q   <= '0;
			idx_q     <= '0;
			wrapped_q <= 1'b0;
		end else begin
			playing_q <= playing_d;
			if (start) begin
				looping_q <= cmd.loop_en;
				clip_q    <= clip_new;
				tail_q    <= MIX_W'(clip_new) - TAIL_MARGIN;
				pos_q     <= '0;
				gain_q    <= cmd.vol;
			end else if (tick) begin
				pos_q  <= pos_cur;
				held_q <= held_cur;
			end
			if (filt_we) begin
				total_q <= total_cur;
				idx_q   <= idx_next;
				if (idx_q == IDX_LAST) begin
					wrapped_q <= 1'b1;
				end
			end
		end
	end

	// Window memory: write the current slot, prefetch the next one
	always_ff @(posedge clk) begin
		if (filt_we) begin
			window_mem[idx_q] <= held_cur;
			rd_q              <= window_mem[idx_next];
		end
	end

	// Register the lane result for the merge stage
	always_ff @(posedge clk) begin
		if (accept) begin
			res_s1.contrib  <= tick ? (bypass ? held_cur : (total_cur >> WINDOW_SHIFT)) : '0;
			res_s1.consumed <= tick && playing_q;
			res_s1.playing  <= playing_d;
		end
	end

endmodule

`default_nettype wire

// ===== sv/msms_merge.sv =====
// ----------------------------------------------------------------------------
// msms_merge
// Sums lane contributions into the mix and builds the channel masks.
// ----------------------------------------------------------------------------
`default_nettype none

module msms_merge #(
	parameter int CHANNELS = 4
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire msms_pkg::lane_res_t           lane_res [CHANNELS],
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [msms_pkg::MIX_W-1:0]         mix,
	output logic [msms_pkg::MASK_W-1:0]        consumed_mask,
	output logic [msms_pkg::MASK_W-1:0]        playing_mask
);
	import msms_pkg::*;

	logic [MIX_W-1:0]  sum;
	logic [MASK_W-1:0] cons_m;
	logic [MASK_W-1:0] play_m;
	logic              valid_s2;

	// Wrapped sum over all lanes
	always_comb begin
		sum = '0;
		for (int c = 0; c < CHANNELS; c++) begin
			sum = sum + lane_res[c].contrib;
		end
	end

	// Masks carry the first four channels only
	for (genvar g = 0; g < MASK_W; g++) begin : g_mask
		if (g < CHANNELS) begin : g_used
			assign cons_m[g] = lane_res[g].consumed;
			assign play_m[g] = lane_res[g].playing;
		end else begin : g_unused
			assign cons_m[g] = 1'b0;
			assign play_m[g] = 1'b0;
		end
	end

	assign in_ready  = !valid_s2 || out_ready;
	assign out_valid = valid_s2;

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			mix           <= sum;
			consumed_mask <= cons_m;
			playing_mask  <= play_m;
		end
	end

endmodule

`default_nettype wire

// ===== sv/multichannel_sample_mixer_smoothing.sv =====
// ----------------------------------------------------------------------------
// multichannel_sample_mixer_smoothing
// Multichannel sample mixer with per-channel moving-average smoothing.
// ----------------------------------------------------------------------------
// Takes one item per clock (tick, start channel, stop channel) and returns one
// result per item through the lane result registers of stage 1 and the merge
// output register. Stage 1 and the output register pass results at full rate
// while the sink takes them; the input stalls only when both hold an item and
// the sink holds off. Each channel is a lane that updates its position, gain
// and boxcar filter in the cycle of the transfer; that state update sets the
// one-item-per-cycle rate. The window memory of a lane is read one slot ahead,
// so the filter never waits on the read. Window entries read as zero until a
// lane's window index has gone round once, so no clearing pass follows reset.
// The merge stage sums all lanes into the wrapped 32-bit mix.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module multichannel_sample_mixer_smoothing #(
	parameter int CHANNELS     = 4,
	parameter int WINDOW_DEPTH = 16,
	parameter int WINDOW_SHIFT = 4,
	parameter int LENGTH_BITS  = 24
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// channel[1:0], length[25:2], loop_enable[26], volume_shift[30:27],
	// sample_zero[46:31], sample_one[62:47], sample_two[78:63],
	// sample_three[94:79], zero pad[95]
	input  wire logic [95:0] s_tdata,
	// kind[1:0]
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// mix[31:0], consumed_mask[35:32], playing_mask[39:36]
	output logic [39:0]      m_tdata
);
	import msms_pkg::*;

	logic                  accept;
	logic                  v1_s1;
	logic                  merge_ready;
	logic [1:0]            chan;
	logic [SAMPLE_W-1:0]   samples [RAW_LANES];
	lane_res_t             lane_res_s1 [CHANNELS];
	logic                  cons_any_s1;
	logic [MIX_W-1:0]      mix;
	logic [MASK_W-1:0]     cons_mask;
	logic [MASK_W-1:0]     play_mask;

	// Unpack the input transfer
	assign chan       = s_tdata[1:0];
	assign samples[0] = s_tdata[46:31];
	assign samples[1] = s_tdata[62:47];
	assign samples[2] = s_tdata[78:63];
	assign samples[3] = s_tdata[94:79];

	// Stage 1 advances when empty or when the output register takes it
	assign s_tready = !v1_s1 || merge_ready;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1_s1 <= 1'b0;
		end else if (s_tready) begin
			v1_s1 <= s_tvalid;
		end
	end

	// One lane per channel
	for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
		lane_cmd_t cmd;

		assign cmd.kind    = kind_t'(s_tuser);
		assign cmd.sel     = (32'(chan) == 32'(g));
		assign cmd.length  = s_tdata[25:2];
		assign cmd.loop_en = s_tdata[26];
		assign cmd.vol     = s_tdata[30:27];
		if (g < RAW_LANES) begin : g_raw
			assign cmd.sample = samples[g];
		end else begin : g_silent
			assign cmd.sample = '0;
		end

		msms_lane #(
			.WINDOW_DEPTH (WINDOW_DEPTH),
			.WINDOW_SHIFT (WINDOW_SHIFT),
			.LENGTH_BITS  (LENGTH_BITS)
		) u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.accept (accept),
			.cmd    (cmd),
			.res_s1 (lane_res_s1[g])
		);
	end

	// Merge lanes into the output register
	msms_merge #(
		.CHANNELS (CHANNELS)
	) u_merge (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (v1_s1),
		.in_ready      (merge_ready),
		.lane_res      (lane_res_s1),
		.out_valid     (m_tvalid),
		.out_ready     (m_tready),
		.mix           (mix),
		.consumed_mask (cons_mask),
		.playing_mask  (play_mask)
	);

	assign m_tdata = {play_mask, cons_mask, mix};

	// Any lane consumed a sample in the item held in stage 1
	always_comb begin
		cons_any_s1 = 1'b0;
		for (int c = 0; c < CHANNELS; c++) begin
			cons_any_s1 = cons_any_s1 | lane_res_s1[c].consumed;
		end
	end

	// Input stalls only when both stages are full and the output is held
	`ASSERT_IMPLIES(a_stall_when_full, clk, arst_n, !s_tready, v1_s1 && m_tvalid && !m_tready)
	// An accepted item always lands in stage 1
	`ASSERT_NEXT(a_accept_fills_s1, clk, arst_n, accept, v1_s1)
	// Only tick items consume samples
	`ASSERT_NEXT(a_consume_on_tick, clk, arst_n, accept && (s_tuser != KIND_TICK), !cons_any_s1)

endmodule

`default_nettype wire
